// ----- design/ilb_pkg.sv -----
// shared types and constants for the indexed list buffer
// command and status codes, controller state, controller/datapath link structs
// no dependencies
`timescale 1ns / 1ps

package ilb_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_READ   = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_REMOVE = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int FieldCmdW   = 3;
	localparam int FieldIdxW   = 6;
	localparam int FieldValW   = 32;
	localparam int FieldLenW   = 7;
	localparam int FieldStatW  = 2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_CAPT   = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_DRAIN  = 7'b0010000,
		S_COMMIT = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic commit;
		logic publish;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic [FieldCmdW-1:0] cmd;
		logic                 ok;
		logic                 shift_done;
		logic                 out_free;
	} sts_t;

endpackage

// ----- design/ilb_ctrl.sv -----
// sequencing controller for the indexed list buffer
// walks each request through execute and result states, with a capture state for read and
// shift, drain and commit states for insert and remove; depends on ilb_pkg
`timescale 1ns / 1ps

module ilb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ilb_pkg::sts_t sts,
	output ilb_pkg::ctl_t ctl
);

	ilb_pkg::state_t state_q;
	ilb_pkg::state_t state_d;

	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		case (state_q)
			ilb_pkg::S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ilb_pkg::S_EXEC;
				end
			end
			ilb_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				if (!sts.ok) begin
					state_d = ilb_pkg::S_FIN;
				end else begin
					case (ilb_pkg::cmd_t'(sts.cmd))
						ilb_pkg::CMD_READ:   state_d = ilb_pkg::S_CAPT;
						ilb_pkg::CMD_INSERT: state_d = ilb_pkg::S_SHIFT;
						ilb_pkg::CMD_REMOVE: state_d = ilb_pkg::S_SHIFT;
						default:             state_d = ilb_pkg::S_FIN;
					endcase
				end
			end
			ilb_pkg::S_CAPT: begin
				state_d = ilb_pkg::S_FIN;
			end
			ilb_pkg::S_SHIFT: begin
				if (sts.shift_done) begin
					state_d = ilb_pkg::S_DRAIN;
				end else begin
					ctl.step = 1'b1;
				end
			end
			ilb_pkg::S_DRAIN: begin
				// no move write here; the last moved word was written while still in the shift state
				state_d = ilb_pkg::S_COMMIT;
			end
			ilb_pkg::S_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = ilb_pkg::S_FIN;
			end
			ilb_pkg::S_FIN: begin
				if (sts.out_free) begin
					ctl.publish = 1'b1;
					state_d     = ilb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ilb_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ilb_pkg::S_IDLE);

	// a failing request never reaches the shift states
	a_err_no_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && !sts.ok) |=> (state_q == ilb_pkg::S_FIN))
		else $error("failing request left the result path");

	// shifting only happens for insert or remove
	a_shift_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (sts.cmd == ilb_pkg::CMD_INSERT || sts.cmd == ilb_pkg::CMD_REMOVE))
		else $error("shift step for a command that does not shift");

	// a result is published only into a free output register
	a_pub_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.publish |-> sts.out_free)
		else $error("result published over a pending one");

endmodule

// ----- design/ilb_dpath.sv -----
// datapath for the indexed list buffer: word store, length, shift pointer,
// move pipeline and result register
// depends on ilb_pkg
`timescale 1ns / 1ps

module ilb_dpath #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ilb_pkg::ctl_t                    ctl,
	output ilb_pkg::sts_t                    sts,
	input  logic [ilb_pkg::FieldCmdW-1:0]    cmd,
	input  logic [ilb_pkg::FieldIdxW-1:0]    index,
	input  logic [ilb_pkg::FieldValW-1:0]    value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ilb_pkg::FieldValW-1:0]    read_value,
	output logic [ilb_pkg::FieldStatW-1:0]   status,
	output logic [ilb_pkg::FieldLenW-1:0]    length,
	output logic                             is_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + ilb_pkg::FieldIdxW;

	logic [ilb_pkg::FieldValW-1:0] mem [DEPTH];

	logic [ilb_pkg::FieldCmdW-1:0]  cmd_q;
	logic [ilb_pkg::FieldIdxW-1:0]  idx_q;
	logic [ilb_pkg::FieldValW-1:0]  val_q;
	logic [ilb_pkg::FieldValW-1:0]  rv_q;
	logic [ilb_pkg::FieldStatW-1:0] st_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  ptr_q;
	logic                           cap_s1;
	logic                           mv_vld_s1;
	logic [AW-1:0]                  mv_dst_s1;
	logic [ilb_pkg::FieldValW-1:0]  rdata_s1;

	logic                           out_valid_q;
	logic [ilb_pkg::FieldValW-1:0]  read_value_q;
	logic [ilb_pkg::FieldStatW-1:0] status_q;
	logic [ilb_pkg::FieldLenW-1:0]  length_q;
	logic                           is_empty_q;

	logic [XW-1:0]                  idx_ext;
	logic [XW-1:0]                  cnt_ext;
	logic [CW-1:0]                  ptr_m1;
	logic                           in_range;
	logic                           full;
	logic                           is_ins;
	logic                           is_rd;
	logic [ilb_pkg::FieldStatW-1:0] st_c;
	logic                           ok_c;

	logic                           cmd_we;
	logic [AW-1:0]                  cmd_waddr;
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [ilb_pkg::FieldValW-1:0]  mem_wdata;
	logic                           mem_re;
	logic [AW-1:0]                  mem_raddr;

	assign idx_ext  = {{CW{1'b0}}, idx_q};
	assign cnt_ext  = {{ilb_pkg::FieldIdxW{1'b0}}, cnt_q};
	assign ptr_m1   = ptr_q - CW'(1);
	assign in_range = (idx_ext < cnt_ext);
	assign full     = (cnt_q == CW'(DEPTH));
	assign is_ins   = (cmd_q == ilb_pkg::CMD_INSERT);
	assign is_rd    = (cmd_q == ilb_pkg::CMD_READ) || (cmd_q == ilb_pkg::CMD_REMOVE);

	always_comb begin
		case (ilb_pkg::cmd_t'(cmd_q))
			ilb_pkg::CMD_APPEND: st_c = full ? ilb_pkg::ST_FULL : ilb_pkg::ST_OK;
			ilb_pkg::CMD_READ,
			ilb_pkg::CMD_WRITE,
			ilb_pkg::CMD_REMOVE: st_c = in_range ? ilb_pkg::ST_OK : ilb_pkg::ST_RANGE;
			ilb_pkg::CMD_INSERT: begin
				if (!in_range) st_c = ilb_pkg::ST_RANGE;
				else if (full) st_c = ilb_pkg::ST_FULL;
				else           st_c = ilb_pkg::ST_OK;
			end
			default:             st_c = ilb_pkg::ST_OK;
		endcase
	end

	assign ok_c = (st_c == ilb_pkg::ST_OK);

	// store port selection; move writes only occur in shift cycles
	always_comb begin
		cmd_we    = 1'b0;
		cmd_waddr = idx_ext[AW-1:0];
		mem_re    = 1'b0;
		mem_raddr = idx_ext[AW-1:0];
		if (ctl.exec && ok_c) begin
			case (ilb_pkg::cmd_t'(cmd_q))
				ilb_pkg::CMD_APPEND: begin
					cmd_we    = 1'b1;
					cmd_waddr = cnt_q[AW-1:0];
				end
				ilb_pkg::CMD_WRITE:  cmd_we = 1'b1;
				ilb_pkg::CMD_READ:   mem_re = 1'b1;
				ilb_pkg::CMD_REMOVE: mem_re = 1'b1;
				default: ;
			endcase
		end
		if (ctl.step) begin
			mem_re    = 1'b1;
			mem_raddr = is_ins ? ptr_m1[AW-1:0] : ptr_q[AW-1:0];
		end
		if (ctl.commit && is_ins) begin
			cmd_we = 1'b1;
		end
	end

	assign mem_we    = cmd_we || mv_vld_s1;
	assign mem_waddr = mv_vld_s1 ? mv_dst_s1 : cmd_waddr;
	assign mem_wdata = mv_vld_s1 ? rdata_s1 : val_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cap_s1      <= 1'b0;
			mv_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cap_s1    <= ctl.exec && ok_c && is_rd;
			mv_vld_s1 <= ctl.step;
			if (ctl.exec && ok_c) begin
				case (ilb_pkg::cmd_t'(cmd_q))
					ilb_pkg::CMD_APPEND: cnt_q <= cnt_q + CW'(1);
					ilb_pkg::CMD_CLEAR:  cnt_q <= '0;
					default: ;
				endcase
			end
			if (ctl.commit) begin
				cnt_q <= is_ins ? cnt_q + CW'(1) : cnt_q - CW'(1);
			end
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			idx_q <= index;
			val_q <= value;
			rv_q  <= '0;
		end
		if (cap_s1) begin
			rv_q <= rdata_s1;
		end
		if (ctl.exec) begin
			st_q <= st_c;
			// insert walks the destination down from the end, remove walks the source up
			ptr_q <= is_ins ? cnt_q : idx_ext[CW-1:0] + CW'(1);
		end
		if (ctl.step) begin
			ptr_q     <= is_ins ? ptr_m1 : ptr_q + CW'(1);
			mv_dst_s1 <= is_ins ? ptr_q[AW-1:0] : ptr_m1[AW-1:0];
		end
		if (ctl.publish) begin
			read_value_q <= rv_q;
			status_q     <= st_q;
			length_q     <= cnt_ext[ilb_pkg::FieldLenW-1:0];
			is_empty_q   <= (cnt_q == '0);
		end
	end

	assign sts.cmd        = cmd_q;
	assign sts.ok         = ok_c;
	assign sts.shift_done = (ptr_q == (is_ins ? idx_ext[CW-1:0] : cnt_q));
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign length     = length_q;
	assign is_empty   = is_empty_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("length above store depth");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mv_vld_s1 && cmd_we))
		else $error("move write collides with a request write");

	a_err_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && !ok_c) |=> $stable(cnt_q))
		else $error("failing request changed the length");

endmodule

// ----- design/indexed_list_buffer_top.sv -----
// top level of the indexed list buffer: ordered list of 32-bit words
// instantiates ilb_ctrl and ilb_dpath, depends on ilb_pkg
//
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | cmd, index, value
//   out     | out_valid | out_stall | read_value, status, length, is_empty
//
// one request at a time; append, write, clear, unused codes and failing requests publish
// after the execute state, read after a capture state, insert and remove after shifting
// n entries (up to DEPTH-1) one word a cycle through the single read and single write port
// of the store, then drain and commit; the next request is taken once back in idle
// reset clears the length and control state; store contents stay undefined until written
// a stalled result holds the next request in its final state until the register frees
`timescale 1ns / 1ps

module indexed_list_buffer_top #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ilb_pkg::FieldCmdW-1:0]  cmd,
	input  logic [ilb_pkg::FieldIdxW-1:0]  index,
	input  logic [ilb_pkg::FieldValW-1:0]  value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ilb_pkg::FieldValW-1:0]  read_value,
	output logic [ilb_pkg::FieldStatW-1:0] status,
	output logic [ilb_pkg::FieldLenW-1:0]  length,
	output logic                           is_empty
);

	ilb_pkg::ctl_t ctl;
	ilb_pkg::sts_t sts;

	ilb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	ilb_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status),
		.length     (length),
		.is_empty   (is_empty)
	);

endmodule
